>>> hw/rtl/wic_pkg.sv
// Package for the weighted index centroid core: payload structs, status codes,
// command and status structs between controller and datapath, and shared constants.
// No dependencies.
`default_nettype none

package wic_pkg;

   localparam int SAMPLE_BITS        = 16;
   localparam int RANGE_BITS         = 32;
   localparam int VALUE_BITS         = 32;
   localparam int DEFAULT_MAX_LENGTH = 4096;

   localparam logic [RANGE_BITS-1:0] RANGE_RESET   = 32'h0001_0000;
   localparam logic [VALUE_BITS-1:0] SAT_POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [VALUE_BITS-1:0] SAT_NEG_LIMIT = 32'h8000_0000;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SHORT    = 2'd1,
      STATUS_ZERO_SUM = 2'd2,
      STATUS_TOO_LONG = 2'd3
   } wic_status_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } wic_req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] centroid_value;
      wic_status_type               status;
   } wic_rsp_type;

   typedef struct packed {
      logic acc_en;
      logic clear;
      logic start;
      logic mul_step;
      logic div_step;
      logic round_step;
      logic emit_special;
      logic emit_calc;
   } wic_cmd_type;

   typedef struct packed {
      logic special;
   } wic_stat_type;

endpackage

`default_nettype wire

>>> hw/rtl/wic_ctrl.sv
// Controller of the weighted index centroid core: sequences accumulation, the
// shift-and-add multiply, the restoring division and result hand-off. Uses wic_pkg.
`default_nettype none

module wic_ctrl #(
   parameter int MAX_LENGTH = wic_pkg::DEFAULT_MAX_LENGTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_last,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire wic_pkg::wic_stat_type stat,
   output wic_pkg::wic_cmd_type      cmd
);
   import wic_pkg::*;

   localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
   localparam int WS_W   = SAMPLE_BITS + 2 * CNT_W;
   localparam int NUM_W  = WS_W + RANGE_BITS;
   localparam int STEP_W = $clog2(NUM_W);

   typedef enum logic [2:0] {
      ST_ACC,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_ROUND,
      ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_ACC);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_ACC: begin
            if (req_valid) begin
               cmd.acc_en = 1'b1;
               if (req_last) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (stat.special) begin
               if (slot_free) begin
                  cmd.emit_special = 1'b1;
                  cmd.clear        = 1'b1;
                  rsp_valid_in     = 1'b1;
                  state_in         = ST_ACC;
               end
            end else begin
               cmd.start = 1'b1;
               cmd.clear = 1'b1;
               step_in   = STEP_W'(RANGE_BITS - 1);
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               step_in  = STEP_W'(NUM_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.emit_calc = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/wic_dp.sv
// Datapath of the weighted index centroid core: accumulators, range register,
// shift-and-add multiplier, restoring divider and result register. Uses wic_pkg.
`default_nettype none

module wic_dp #(
   parameter int MAX_LENGTH = wic_pkg::DEFAULT_MAX_LENGTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire wic_pkg::wic_cmd_type            cmd,
   output wic_pkg::wic_stat_type                stat,
   input  wire wic_pkg::wic_req_type            req_data,
   input  wire logic                            csr_write,
   input  wire logic [wic_pkg::RANGE_BITS-1:0] csr_data,
   output wic_pkg::wic_rsp_type                 rsp_data
);
   import wic_pkg::*;

   localparam int CNT_W = $clog2(MAX_LENGTH + 1);
   localparam int WT_W  = SAMPLE_BITS + CNT_W;
   localparam int WS_W  = SAMPLE_BITS + 2 * CNT_W;
   localparam int NUM_W = WS_W + RANGE_BITS;
   localparam int DEN_W = WT_W + CNT_W;
   localparam int QUO_W = NUM_W + 1;

   logic [RANGE_BITS-1:0]         range_ff;
   logic [CNT_W-1:0]              count_ff;
   logic signed [WS_W-1:0]        ws_ff;
   logic signed [WT_W-1:0]        wt_ff;
   logic                          ovf_ff;
   logic                          neg_ff;
   logic [DEN_W-1:0]              den_ff;
   logic [RANGE_BITS-1:0]         mplr_ff;
   logic [WS_W-1:0]               mcand_ff;
   logic [NUM_W-1:0]              prod_ff;
   logic [DEN_W-1:0]              rem_ff;
   logic [QUO_W-1:0]              quo_ff;
   wic_rsp_type                   rsp_ff;

   logic signed [CNT_W+SAMPLE_BITS:0] idx_prod;
   wic_status_type                    check_status;
   logic [WS_W-1:0]                   ws_mag;
   logic [WT_W-1:0]                   wt_mag;
   logic [CNT_W-1:0]                  cnt_m1;
   logic [DEN_W-1:0]                  den_prod;
   logic [DEN_W:0]                    trial;
   logic [DEN_W:0]                    diff;
   logic                              ge;
   logic                              round_up;
   logic [QUO_W-1:0]                  limit;
   logic [VALUE_BITS-1:0]             mag;
   logic [VALUE_BITS-1:0]             value;

   assign idx_prod = $signed({1'b0, count_ff}) * req_data.sample;

   always_comb begin
      priority if (ovf_ff) begin
         check_status = STATUS_TOO_LONG;
      end else if (count_ff < CNT_W'(2)) begin
         check_status = STATUS_SHORT;
      end else if (wt_ff == '0) begin
         check_status = STATUS_ZERO_SUM;
      end else begin
         check_status = STATUS_OK;
      end
   end

   assign stat.special = (check_status != STATUS_OK);

   assign ws_mag   = ws_ff[WS_W-1] ? (~ws_ff + WS_W'(1)) : ws_ff;
   assign wt_mag   = wt_ff[WT_W-1] ? (~wt_ff + WT_W'(1)) : wt_ff;
   assign cnt_m1   = count_ff - CNT_W'(1);
   assign den_prod = DEN_W'(wt_mag) * DEN_W'(cnt_m1);

   assign trial = {rem_ff, prod_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   assign round_up = ({rem_ff, 1'b0} >= {1'b0, den_ff});

   assign limit = neg_ff ? QUO_W'(SAT_NEG_LIMIT) : QUO_W'(SAT_POS_LIMIT);
   assign mag   = (quo_ff > limit) ? limit[VALUE_BITS-1:0] : quo_ff[VALUE_BITS-1:0];
   assign value = neg_ff ? (~mag + VALUE_BITS'(1)) : mag;

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= RANGE_RESET;
         count_ff <= '0;
         ws_ff    <= '0;
         wt_ff    <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            range_ff <= csr_data;
         end
         if (cmd.clear) begin
            count_ff <= '0;
            ws_ff    <= '0;
            wt_ff    <= '0;
            ovf_ff   <= 1'b0;
         end else if (cmd.acc_en) begin
            if (count_ff < CNT_W'(MAX_LENGTH)) begin
               ws_ff    <= ws_ff + WS_W'(idx_prod);
               wt_ff    <= wt_ff + WT_W'(req_data.sample);
               count_ff <= count_ff + CNT_W'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         neg_ff   <= ws_ff[WS_W-1] ^ wt_ff[WT_W-1];
         den_ff   <= den_prod;
         mcand_ff <= ws_mag;
         mplr_ff  <= range_ff;
         prod_ff  <= '0;
         rem_ff   <= '0;
      end
      if (cmd.mul_step) begin
         prod_ff <= {prod_ff[NUM_W-2:0], 1'b0}
                  + (mplr_ff[RANGE_BITS-1] ? NUM_W'(mcand_ff) : '0);
         mplr_ff <= {mplr_ff[RANGE_BITS-2:0], 1'b0};
      end
      if (cmd.div_step) begin
         rem_ff  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         prod_ff <= {prod_ff[NUM_W-2:0], ge};
      end
      if (cmd.round_step) begin
         quo_ff <= {1'b0, prod_ff} + QUO_W'(round_up);
      end
      if (cmd.emit_special) begin
         rsp_ff.centroid_value <= '0;
         rsp_ff.status         <= check_status;
      end else if (cmd.emit_calc) begin
         rsp_ff.centroid_value <= value;
         rsp_ff.status         <= STATUS_OK;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/weighted_index_centroid_core.sv
// Top level of the weighted index centroid core: joins the controller and the datapath.
// Uses wic_pkg, wic_ctrl and wic_dp.
`default_nettype none

// Samples of an array are taken one per cycle while the core is not busy, the last one
// flagged; that sample closes the array and yields one transaction on the result
// channel. A result with a status other than ok (too long, single element, zero
// weight sum) is set in the check state and registered once the result slot is free.
// An ok result is computed by a shift-and-add multiplier that takes one bit of the
// range each cycle and a restoring divider that produces one quotient bit each
// cycle, followed by a rounding step; the next array is accepted once the result
// has been placed in the result register.
// The range register may be written at any time the core holds no open array.

module weighted_index_centroid_core #(
   parameter int MAX_LENGTH = wic_pkg::DEFAULT_MAX_LENGTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire wic_pkg::wic_req_type            req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output wic_pkg::wic_rsp_type                 rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [wic_pkg::RANGE_BITS-1:0] csr_data
);
   import wic_pkg::*;

   wic_cmd_type  cmd;
   wic_stat_type stat;

   assign csr_ready = 1'b1;

   wic_ctrl #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   wic_dp #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> hw/rtl/wic_checker.sv
// Port-level checks for the weighted index centroid core, and the bind that
// attaches them to the top level. Uses wic_pkg.
`default_nettype none

module wic_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire wic_pkg::wic_req_type            req_data,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire wic_pkg::wic_rsp_type            rsp_data
);
   import wic_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result transaction changed or was dropped.");

   a_special_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |-> (rsp_data.centroid_value == '0))
      else $error("Result with an error status carries a non-zero value.");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last |=> req_stall)
      else $error("Sample accepted directly after the closing sample of an array.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid after reset.");

endmodule

bind weighted_index_centroid_core wic_checker u_wic_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> sim/wic_centroid_audit.sv
// Watches the request, result and range register channels of the weighted index centroid
// core, predicts every centroid result and compares it field by field with what arrives.
// Depends on wic_pkg only.
module wic_centroid_audit
   import wic_pkg::*;
#(
   parameter int MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  wic_req_type           req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  wic_rsp_type           rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [RANGE_BITS-1:0] csr_data,
   output int                    fault_count,
   output int                    centroids_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   wic_rsp_type           expected_centroids[$];
   logic [RANGE_BITS-1:0] scale_range;
   int unsigned           element_count;
   longint                index_weighted_sum;
   longint                weight_sum;
   bit                    too_long_seen;

   initial begin
      fault_count           = 0;
      centroids_outstanding = 0;
   end

   function automatic logic [VALUE_BITS-1:0] centroid_q16_of(int unsigned n, longint weighted,
                                                             longint weights,
                                                             logic [RANGE_BITS-1:0] span);
      logic [63:0]           abs_weighted;
      logic [63:0]           abs_weights;
      logic [127:0]          numerator;
      logic [127:0]          denominator;
      logic [127:0]          quotient;
      logic [127:0]          remainder;
      logic [VALUE_BITS-1:0] limit;
      logic [VALUE_BITS-1:0] magnitude_q;
      bit                    negative;
      negative     = (weighted < 0) != (weights < 0);
      abs_weighted = (weighted < 0) ? -weighted : weighted;
      abs_weights  = (weights < 0) ? -weights : weights;
      numerator    = {64'd0, abs_weighted} * {96'd0, span};
      denominator  = {64'd0, abs_weights} * {96'd0, 32'(n - 1)};
      quotient     = numerator / denominator;
      remainder    = numerator % denominator;
      if (remainder >= denominator - remainder) begin
         quotient = quotient + 1;
      end
      limit       = negative ? SAT_NEG_LIMIT : SAT_POS_LIMIT;
      magnitude_q = (quotient > {96'd0, limit}) ? limit : quotient[VALUE_BITS-1:0];
      return negative ? -magnitude_q : magnitude_q;
   endfunction

   task automatic clear_sums();
      element_count      = 0;
      index_weighted_sum = 0;
      weight_sum         = 0;
      too_long_seen      = 1'b0;
   endtask

   task automatic report_mismatch(string what, longint wanted, longint seen);
      if (fault_count < 40) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, wanted, seen);
      end
      fault_count++;
   endtask

   always @(posedge clock) begin
      wic_rsp_type seen;
      wic_rsp_type wanted;
      longint      weight;
      if (reset) begin
         expected_centroids.delete();
         scale_range = RANGE_RESET;
         clear_sums();
      end else begin
         if (csr_valid && csr_ready) begin
            scale_range = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            seen = rsp_data;
            if (expected_centroids.size() == 0) begin
               report_mismatch("unexpected result transaction, centroid_value", 0,
                               seen.centroid_value);
            end else begin
               wanted = expected_centroids.pop_front();
               if (seen.centroid_value !== wanted.centroid_value) begin
                  report_mismatch("centroid_value", wanted.centroid_value, seen.centroid_value);
               end
               if (seen.status !== wanted.status) begin
                  report_mismatch("status", wanted.status, seen.status);
               end
            end
         end
         if (req_valid && !req_stall) begin
            weight = longint'(req_data.sample);
            if (element_count < MAX_LENGTH) begin
               index_weighted_sum += longint'(element_count) * weight;
               weight_sum         += weight;
               element_count++;
            end else begin
               too_long_seen = 1'b1;
            end
            if (req_data.last) begin
               wanted.centroid_value = '0;
               if (too_long_seen) begin
                  wanted.status = STATUS_TOO_LONG;
               end else if (element_count < 2) begin
                  wanted.status = STATUS_SHORT;
               end else if (weight_sum == 0) begin
                  wanted.status = STATUS_ZERO_SUM;
               end else begin
                  wanted.status         = STATUS_OK;
                  wanted.centroid_value = centroid_q16_of(element_count, index_weighted_sum,
                                                          weight_sum, scale_range);
               end
               expected_centroids.push_back(wanted);
               clear_sums();
            end
         end
      end
      centroids_outstanding <= expected_centroids.size();
   end

endmodule

>>> sim/tb_weighted_index_centroid_core.sv
// Top of the testbench for the weighted index centroid core: clock, reset, stimulus on the
// sample and range register channels, result back-pressure, watchdog and verdict.
// Depends on wic_pkg, weighted_index_centroid_core and wic_centroid_audit.
module tb_weighted_index_centroid_core;
   timeunit 1ns;
   timeprecision 1ps;

   import wic_pkg::*;

   localparam int IDLE_PERCENT    = 27;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 120;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_ITEMS     = 90;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   wic_req_type           req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   wic_rsp_type           rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [RANGE_BITS-1:0] csr_data  = '0;

   bit      idle_on         = 1'b1;
   int      hold_off_asked  = 0;
   int      hold_off_served = 0;
   int      hold_off_left   = 0;
   int      quiet_cycles    = 0;
   int      fault_count;
   int      centroids_outstanding;
   shortint array_buf[$];

   weighted_index_centroid_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   wic_centroid_audit u_audit (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_data              (req_data),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_data              (rsp_data),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data),
      .fault_count           (fault_count),
      .centroids_outstanding (centroids_outstanding)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_asked != hold_off_served) begin
         rsp_stall       <= 1'b1;
         hold_off_served <= hold_off_asked;
         hold_off_left   <= HOLD_OFF_CYCLES;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[weighted_index_centroid_core] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic shortint pick_sample(int style);
      case (style)
         0: return shortint'($urandom_range(0, 65535));
         1: begin
            case ($urandom_range(0, 4))
               0: return 16'sh7FFF;
               1: return -16'sh8000;
               2: return 16'sd0;
               3: return 16'sd1;
               default: return -16'sd1;
            endcase
         end
         2: return shortint'(int'($urandom_range(0, 16)) - 8);
         default: return shortint'($urandom_range(0, 32767));
      endcase
   endfunction

   task automatic send_sample(shortint value, bit closes);
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {value, closes};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_buffer();
      foreach (array_buf[i]) begin
         send_sample(array_buf[i], i == array_buf.size() - 1);
      end
   endtask

   task automatic build_random_array();
      int roll;
      int len;
      int style;
      int total;
      bit zero_sum;
      roll     = $urandom_range(0, 99);
      len      = (roll < 8) ? 1 : (roll < 88) ? $urandom_range(2, 12) : $urandom_range(13, 80);
      zero_sum = (len > 1) && ($urandom_range(0, 9) == 0);
      style    = zero_sum ? 2 : $urandom_range(0, 3);
      total    = 0;
      array_buf.delete();
      repeat (len - 1) begin
         array_buf.push_back(pick_sample(style));
         total += array_buf[$];
      end
      array_buf.push_back(zero_sum ? shortint'(-total) : pick_sample(style));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (centroids_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_range(logic [RANGE_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase_items;
      bit held;
      bit paused;
      logic [RANGE_BITS-1:0] phase_range;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      array_buf = '{16'sh7FFF};
      send_buffer();
      array_buf = '{-16'sh8000, 16'sh7FFF};
      send_buffer();
      array_buf = '{16'sd0, 16'sd0};
      send_buffer();
      array_buf = '{16'sd1, -16'sd1};
      send_buffer();
      array_buf = '{16'sd0, 16'sh7FFF};
      send_buffer();
      array_buf = '{-16'sd1, 16'sd2};
      send_buffer();
      array_buf = '{16'sd1, 16'sd1, 16'sd1};
      send_buffer();
      array_buf = '{-16'sd3, 16'sd1, 16'sd0};
      send_buffer();
      array_buf = '{16'sh7FFF, -16'sh8000, 16'sd1, 16'sd0, -16'sd1};
      send_buffer();
      settle();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         settle();
         case (phase)
            0: phase_range = 32'd0;
            1: phase_range = 32'hFFFF_FFFF;
            2: phase_range = 32'd1;
            3: phase_range = 32'd3;
            4: phase_range = RANGE_RESET;
            5: phase_range = $urandom;
            6: phase_range = $urandom_range(1, 1000);
            default: phase_range = 32'h0008_0000;
         endcase
         write_range(phase_range);
         idle_on     <= (phase != 3);
         phase_items = 0;
         held        = 1'b0;
         paused      = 1'b0;
         while (phase_items < PHASE_ITEMS) begin
            if (!held && phase_items >= 20 && (phase == 1 || phase == 5)) begin
               hold_off_asked <= hold_off_asked + 1;
               held = 1'b1;
            end
            if (!paused && phase_items >= 45 && phase == 6) begin
               settle();
               paused = 1'b1;
            end
            build_random_array();
            send_buffer();
            phase_items += array_buf.size();
         end
      end
      settle();

      if (fault_count == 0 && centroids_outstanding == 0) begin
         $display("[weighted_index_centroid_core] OK");
      end else begin
         $display("[weighted_index_centroid_core] ERROR");
      end
      $finish;
   end

endmodule
